FILE: hdl/smt_pkg.sv
package smt_pkg;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_CNT_LO,
      PH_TYPE,
      PH_DELTA_HI,
      PH_DELTA_LO,
      PH_NLOC_HI,
      PH_NLOC_LO,
      PH_TAG,
      PH_PAY_HI,
      PH_PAY_LO,
      PH_NSTK_HI,
      PH_NSTK_LO
   } phase_type;

   typedef enum logic [2:0] {
      REC_FRAME    = 3'd0,
      REC_ITEM     = 3'd1,
      REC_STACK    = 3'd2,
      REC_BAD_TYPE = 3'd3,
      REC_BAD_TAG  = 3'd4
   } rec_kind_type;

   // frame type ranges
   localparam logic [7:0] SAME_MAX         = 8'd63;
   localparam logic [7:0] SAME_LOCALS_BASE = 8'd64;
   localparam logic [7:0] SAME_LOCALS_MAX  = 8'd127;
   localparam logic [7:0] RESERVED_MAX     = 8'd246;
   localparam logic [7:0] SAME_LOCALS_WIDE = 8'd247;
   localparam logic [7:0] CHOP_MAX         = 8'd250;
   localparam logic [7:0] SAME_WIDE        = 8'd251;
   localparam logic [7:0] APPEND_MAX       = 8'd254;
   localparam logic [7:0] FULL_FRAME       = 8'd255;

   // verification tags
   localparam logic [7:0] TAG_OBJECT = 8'd7;
   localparam logic [7:0] TAG_UNINIT = 8'd8;
   localparam logic [7:0] TAG_MAX    = 8'd8;

   typedef struct packed {
      rec_kind_type kind;
      logic [15:0]  frame_index;
      logic [7:0]   frame_code;
      logic [15:0]  pc_delta;
      logic [15:0]  item_count;
      logic         item_section;
      logic [7:0]   item_tag;
      logic [15:0]  item_payload;
      logic         table_done;
   } rec_type;

endpackage

FILE: hdl/smt_req_if.sv
interface smt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_of_table;

   modport source (output valid, output data_byte, output start_of_table, input ready);
   modport sink (input valid, input data_byte, input start_of_table, output ready);
endinterface

FILE: hdl/smt_rsp_if.sv
interface smt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  record_kind;
   logic [15:0] frame_index;
   logic [7:0]  frame_code;
   logic [15:0] pc_delta;
   logic [15:0] item_count;
   logic        item_section;
   logic [7:0]  item_tag;
   logic [15:0] item_payload;
   logic        table_done;

   modport source (
      output valid, output record_kind, output frame_index, output frame_code,
      output pc_delta, output item_count, output item_section, output item_tag,
      output item_payload, output table_done, input ready
   );
   modport sink (
      input valid, input record_kind, input frame_index, input frame_code,
      input pc_delta, input item_count, input item_section, input item_tag,
      input item_payload, input table_done, output ready
   );
endinterface

FILE: hdl/stack_map_table_parser.sv
// Stack map table parser.
// The req channel takes the attribute body one byte per item; start_of_table
// marks the high byte of the big-endian entry count and always restarts parsing.
// The rsp channel gives at most one record per byte: frame headers, verification
// items, full-frame stack counts, and bad-type / bad-tag errors. After an error,
// after the last frame and before the first start, bytes are taken and dropped.
// Throughput is one byte per cycle while req.ready is high: a byte updates the
// phase register and counters through one level of logic and its record lands
// in the output register, or in the skid register while the output register is
// held. The output side is a two-entry buffer (output register plus skid
// register); req.ready is low only while both entries are full, so a byte can
// still be taken while one record waits for rsp.ready.
// Reset (synchronous, active high) empties both entries and returns the parser
// to idle; no record is lost or repeated across a stall on either side.
module stack_map_table_parser (
   input logic clock,
   input logic reset,
   smt_req_if.sink   req,
   smt_rsp_if.source rsp
);
   import smt_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [15:0] frames_left_ff, frames_left_in;
   logic [15:0] items_left_ff, items_left_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  acc_ff, acc_in;
   logic [15:0] delta_ff, delta_in;
   logic [15:0] index_ff, index_in;
   logic [7:0]  tag_ff, tag_in;
   logic        section_ff, section_in;

   rec_type     out_ff, skid_ff, rec;
   logic        out_valid_ff, skid_valid_ff;

   logic        in_fire, push_rec, push, pop;
   logic        do_item, do_frame_end;
   logic [7:0]  item_tag;
   logic [15:0] item_pay;
   logic [15:0] word;
   logic [15:0] frames_dec, items_dec;
   logic        frame_last;

   assign in_fire = req.valid && req.ready;
   assign pop     = out_valid_ff && rsp.ready;
   assign push    = in_fire && push_rec;

   always_comb begin
      phase_in       = phase_ff;
      frames_left_in = frames_left_ff;
      items_left_in  = items_left_ff;
      type_in        = type_ff;
      acc_in         = acc_ff;
      delta_in       = delta_ff;
      index_in       = index_ff;
      tag_in         = tag_ff;
      section_in     = section_ff;
      push_rec       = 1'b0;
      do_item        = 1'b0;
      do_frame_end   = 1'b0;
      item_tag       = tag_ff;
      item_pay       = '0;
      rec            = '0;
      rec.kind       = REC_FRAME;

      word       = {acc_ff, req.data_byte};
      frames_dec = (frames_left_ff != 16'd0) ? frames_left_ff - 16'd1 : 16'd0;
      items_dec  = (items_left_ff != 16'd0) ? items_left_ff - 16'd1 : 16'd0;
      frame_last = (frames_dec == 16'd0);

      if (req.start_of_table) begin
         frames_left_in = '0;
         items_left_in  = '0;
         type_in        = '0;
         delta_in       = '0;
         index_in       = '0;
         tag_in         = '0;
         section_in     = 1'b0;
         acc_in         = req.data_byte;
         phase_in       = PH_CNT_LO;
      end else begin
         unique case (phase_ff)
            PH_CNT_LO: begin
               frames_left_in = word;
               index_in       = '0;
               phase_in       = (word != 16'd0) ? PH_TYPE : PH_IDLE;
            end
            PH_TYPE: begin
               type_in       = req.data_byte;
               delta_in      = '0;
               section_in    = 1'b0;
               items_left_in = '0;
               if (req.data_byte <= SAME_MAX) begin
                  delta_in       = {8'h00, req.data_byte};
                  push_rec       = 1'b1;
                  rec.item_count = '0;
                  do_frame_end   = 1'b1;
               end else if (req.data_byte <= SAME_LOCALS_MAX) begin
                  delta_in       = {8'h00, req.data_byte - SAME_LOCALS_BASE};
                  section_in     = 1'b1;
                  items_left_in  = 16'd1;
                  push_rec       = 1'b1;
                  rec.item_count = 16'd1;
                  phase_in       = PH_TAG;
               end else if (req.data_byte <= RESERVED_MAX) begin
                  push_rec = 1'b1;
                  rec.kind = REC_BAD_TYPE;
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = PH_DELTA_HI;
               end
            end
            PH_DELTA_HI: begin
               acc_in   = req.data_byte;
               phase_in = PH_DELTA_LO;
            end
            PH_DELTA_LO: begin
               delta_in = word;
               if (type_ff == FULL_FRAME) begin
                  phase_in = PH_NLOC_HI;
               end else if (type_ff == SAME_LOCALS_WIDE) begin
                  section_in     = 1'b1;
                  items_left_in  = 16'd1;
                  push_rec       = 1'b1;
                  rec.item_count = 16'd1;
                  phase_in       = PH_TAG;
               end else if (type_ff <= SAME_WIDE) begin
                  // chop and wide same frames carry no items
                  push_rec       = 1'b1;
                  rec.item_count = '0;
                  do_frame_end   = 1'b1;
               end else begin
                  // append: one local per type step above the wide same frame
                  section_in     = 1'b0;
                  items_left_in  = {8'h00, type_ff - SAME_WIDE};
                  push_rec       = 1'b1;
                  rec.item_count = {8'h00, type_ff - SAME_WIDE};
                  phase_in       = PH_TAG;
               end
            end
            PH_NLOC_HI: begin
               acc_in   = req.data_byte;
               phase_in = PH_NLOC_LO;
            end
            PH_NSTK_HI: begin
               acc_in   = req.data_byte;
               phase_in = PH_NSTK_LO;
            end
            PH_PAY_HI: begin
               acc_in   = req.data_byte;
               phase_in = PH_PAY_LO;
            end
            PH_NLOC_LO: begin
               items_left_in  = word;
               section_in     = 1'b0;
               push_rec       = 1'b1;
               rec.item_count = word;
               phase_in       = (word != 16'd0) ? PH_TAG : PH_NSTK_HI;
            end
            PH_TAG: begin
               tag_in = req.data_byte;
               if (req.data_byte > TAG_MAX) begin
                  push_rec       = 1'b1;
                  rec.kind       = REC_BAD_TAG;
                  rec.item_count = items_left_ff;
                  rec.item_tag   = req.data_byte;
                  phase_in       = PH_IDLE;
               end else if (req.data_byte == TAG_OBJECT || req.data_byte == TAG_UNINIT) begin
                  phase_in = PH_PAY_HI;
               end else begin
                  do_item  = 1'b1;
                  item_tag = req.data_byte;
               end
            end
            PH_PAY_LO: begin
               do_item  = 1'b1;
               item_tag = tag_ff;
               item_pay = word;
            end
            PH_NSTK_LO: begin
               items_left_in  = word;
               section_in     = 1'b1;
               push_rec       = 1'b1;
               rec.kind       = REC_STACK;
               rec.item_count = word;
               if (word != 16'd0) begin
                  phase_in = PH_TAG;
               end else begin
                  do_frame_end = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      // one verification item finished
      if (do_item) begin
         items_left_in    = items_dec;
         push_rec         = 1'b1;
         rec.kind         = REC_ITEM;
         rec.item_count   = items_dec;
         rec.item_tag     = item_tag;
         rec.item_payload = item_pay;
         if (items_dec != 16'd0) begin
            phase_in = PH_TAG;
         end else if (!section_ff && type_ff == FULL_FRAME) begin
            phase_in = PH_NSTK_HI;
         end else begin
            do_frame_end = 1'b1;
         end
      end

      rec.frame_index  = index_ff;
      rec.frame_code   = type_in;
      rec.pc_delta     = delta_in;
      rec.item_section = section_in;

      if (do_frame_end) begin
         frames_left_in = frames_dec;
         index_in       = index_ff + 16'd1;
         phase_in       = frame_last ? PH_IDLE : PH_TYPE;
         rec.table_done = frame_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         frames_left_ff <= '0;
         items_left_ff  <= '0;
         index_ff       <= '0;
         section_ff     <= 1'b0;
      end else if (in_fire) begin
         phase_ff       <= phase_in;
         frames_left_ff <= frames_left_in;
         items_left_ff  <= items_left_in;
         index_ff       <= index_in;
         section_ff     <= section_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         type_ff  <= type_in;
         acc_ff   <= acc_in;
         delta_ff <= delta_in;
         tag_ff   <= tag_in;
      end
   end

   // two-entry output buffer; ready only depends on the skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (push) begin
            out_ff <= rec;
         end
      end else if (push) begin
         skid_ff <= rec;
      end
   end

   assign req.ready        = !skid_valid_ff;
   assign rsp.valid        = out_valid_ff;
   assign rsp.record_kind  = out_ff.kind;
   assign rsp.frame_index  = out_ff.frame_index;
   assign rsp.frame_code   = out_ff.frame_code;
   assign rsp.pc_delta     = out_ff.pc_delta;
   assign rsp.item_count   = out_ff.item_count;
   assign rsp.item_section = out_ff.item_section;
   assign rsp.item_tag     = out_ff.item_tag;
   assign rsp.item_payload = out_ff.item_payload;
   assign rsp.table_done   = out_ff.table_done;

   skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while output register empty");

   tag_phase_has_items: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_TAG |-> items_left_ff != 16'd0)
      else $error("waiting for a tag with no items left");

   error_halts: assert property (@(posedge clock) disable iff (reset)
      push && (rec.kind == REC_BAD_TYPE || rec.kind == REC_BAD_TAG) && !rec.table_done
      |=> phase_ff == PH_IDLE)
      else $error("parser did not halt after an error record");

   done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      push && rec.table_done |=> phase_ff == PH_IDLE && frames_left_ff == 16'd0)
      else $error("table done without returning to idle");

   error_never_done: assert property (@(posedge clock) disable iff (reset)
      push && (rec.kind == REC_BAD_TYPE || rec.kind == REC_BAD_TAG) |-> !rec.table_done)
      else $error("error record flagged as table done");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps

module tb;
   import smt_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_BYTES = 400;

   // frame type and tag values without a name in the package
   localparam logic [7:0] SAME_MIN = 8'd0;
   localparam logic [7:0] TAG_TOP  = 8'd0;
   localparam logic [7:0] TAG_LONG = 8'd4;

   logic clock = 1'b0;
   logic reset;

   smt_req_if req_if ();
   smt_rsp_if rsp_if ();

   stack_map_table_parser u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // parser state mirrored by the bench
   phase_type   phase;
   logic [15:0] frames_to_go;
   logic [15:0] items_to_go;
   logic [7:0]  hi_byte;
   logic [7:0]  type_byte;
   logic [7:0]  tag_byte;
   logic [15:0] delta_held;
   logic [15:0] frame_num;
   logic        section;

   rec_type expected_records[$];

   int error_count   = 0;
   int stall_cycles  = 0;
   int parsed_bytes  = 0;
   int records_seen  = 0;
   int kind_seen[5]  = '{default: 0};
   int send_idle_pct = 9;
   int recv_idle_pct = 66;

   function automatic void clear_parser();
      phase        = PH_IDLE;
      frames_to_go = '0;
      items_to_go  = '0;
      hi_byte      = '0;
      type_byte    = '0;
      tag_byte     = '0;
      delta_held   = '0;
      frame_num    = '0;
      section      = 1'b0;
   endfunction

   function automatic rec_type make_rec(rec_kind_type kind, logic [15:0] count,
                                        logic [7:0] tag, logic [15:0] payload);
      rec_type r;
      r.kind         = kind;
      r.frame_index  = frame_num;
      r.frame_code   = type_byte;
      r.pc_delta     = delta_held;
      r.item_count   = count;
      r.item_section = section;
      r.item_tag     = tag;
      r.item_payload = payload;
      r.table_done   = 1'b0;
      return r;
   endfunction

   // returns 1 when the frame just closed was the last of the table
   function automatic logic close_frame();
      if (frames_to_go != 0)
         frames_to_go--;
      frame_num++;
      if (frames_to_go == 0) begin
         phase = PH_IDLE;
         return 1'b1;
      end
      phase = PH_TYPE;
      return 1'b0;
   endfunction

   function automatic rec_type finish_item(logic [15:0] payload);
      rec_type r;
      if (items_to_go != 0)
         items_to_go--;
      r = make_rec(REC_ITEM, items_to_go, tag_byte, payload);
      if (items_to_go != 0)
         phase = PH_TAG;
      else if (!section && type_byte == FULL_FRAME)
         phase = PH_NSTK_HI;
      else
         r.table_done = close_frame();
      return r;
   endfunction

   function automatic void parse_byte(logic [7:0] value, logic first);
      rec_type r;
      logic    emit;
      emit = 1'b0;
      r    = '0;
      if (first) begin
         clear_parser();
         hi_byte = value;
         phase   = PH_CNT_LO;
      end else begin
         case (phase)
            PH_CNT_LO: begin
               frames_to_go = {hi_byte, value};
               frame_num    = '0;
               phase        = (frames_to_go != 0) ? PH_TYPE : PH_IDLE;
            end
            PH_TYPE: begin
               type_byte   = value;
               delta_held  = '0;
               section     = 1'b0;
               items_to_go = '0;
               if (value <= SAME_MAX) begin
                  delta_held   = 16'(value);
                  r            = make_rec(REC_FRAME, 16'd0, 8'd0, 16'd0);
                  r.table_done = close_frame();
                  emit         = 1'b1;
               end else if (value <= SAME_LOCALS_MAX) begin
                  delta_held  = 16'(value - SAME_LOCALS_BASE);
                  section     = 1'b1;
                  items_to_go = 16'd1;
                  r           = make_rec(REC_FRAME, 16'd1, 8'd0, 16'd0);
                  emit        = 1'b1;
                  phase       = PH_TAG;
               end else if (value <= RESERVED_MAX) begin
                  r     = make_rec(REC_BAD_TYPE, 16'd0, 8'd0, 16'd0);
                  emit  = 1'b1;
                  phase = PH_IDLE;
               end else begin
                  phase = PH_DELTA_HI;
               end
            end
            PH_DELTA_HI: begin
               hi_byte = value;
               phase   = PH_DELTA_LO;
            end
            PH_NLOC_HI: begin
               hi_byte = value;
               phase   = PH_NLOC_LO;
            end
            PH_NSTK_HI: begin
               hi_byte = value;
               phase   = PH_NSTK_LO;
            end
            PH_PAY_HI: begin
               hi_byte = value;
               phase   = PH_PAY_LO;
            end
            PH_DELTA_LO: begin
               delta_held = {hi_byte, value};
               if (type_byte == FULL_FRAME) begin
                  phase = PH_NLOC_HI;
               end else if (type_byte == SAME_LOCALS_WIDE) begin
                  section     = 1'b1;
                  items_to_go = 16'd1;
                  r           = make_rec(REC_FRAME, 16'd1, 8'd0, 16'd0);
                  emit        = 1'b1;
                  phase       = PH_TAG;
               end else if (type_byte <= SAME_WIDE) begin
                  r            = make_rec(REC_FRAME, 16'd0, 8'd0, 16'd0);
                  r.table_done = close_frame();
                  emit         = 1'b1;
               end else begin
                  // append: one local per type step above the wide same frame
                  section     = 1'b0;
                  items_to_go = 16'(type_byte - SAME_WIDE);
                  r           = make_rec(REC_FRAME, items_to_go, 8'd0, 16'd0);
                  emit        = 1'b1;
                  phase       = PH_TAG;
               end
            end
            PH_NLOC_LO: begin
               items_to_go = {hi_byte, value};
               section     = 1'b0;
               r           = make_rec(REC_FRAME, items_to_go, 8'd0, 16'd0);
               emit        = 1'b1;
               phase       = (items_to_go != 0) ? PH_TAG : PH_NSTK_HI;
            end
            PH_TAG: begin
               tag_byte = value;
               if (value > TAG_MAX) begin
                  r     = make_rec(REC_BAD_TAG, items_to_go, value, 16'd0);
                  emit  = 1'b1;
                  phase = PH_IDLE;
               end else if (value == TAG_OBJECT || value == TAG_UNINIT) begin
                  phase = PH_PAY_HI;
               end else begin
                  r    = finish_item(16'd0);
                  emit = 1'b1;
               end
            end
            PH_PAY_LO: begin
               r    = finish_item({hi_byte, value});
               emit = 1'b1;
            end
            PH_NSTK_LO: begin
               items_to_go = {hi_byte, value};
               section     = 1'b1;
               r           = make_rec(REC_STACK, items_to_go, 8'd0, 16'd0);
               emit        = 1'b1;
               if (items_to_go != 0)
                  phase = PH_TAG;
               else
                  r.table_done = close_frame();
            end
            default: ;
         endcase
      end
      if (emit)
         expected_records.push_back(r);
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endfunction

   function automatic void check_record();
      rec_type want;
      if (expected_records.size() == 0) begin
         $error("record with nothing expected: kind %0d frame %0d",
                rsp_if.record_kind, rsp_if.frame_index);
         error_count++;
      end else begin
         want = expected_records.pop_front();
         records_seen++;
         kind_seen[want.kind]++;
         check_field("record_kind", 16'(want.kind), 16'(rsp_if.record_kind));
         check_field("frame_index", want.frame_index, rsp_if.frame_index);
         check_field("frame_code", 16'(want.frame_code), 16'(rsp_if.frame_code));
         check_field("pc_delta", want.pc_delta, rsp_if.pc_delta);
         check_field("item_count", want.item_count, rsp_if.item_count);
         check_field("item_section", 16'(want.item_section), 16'(rsp_if.item_section));
         check_field("item_tag", 16'(want.item_tag), 16'(rsp_if.item_tag));
         check_field("item_payload", want.item_payload, rsp_if.item_payload);
         check_field("table_done", 16'(want.table_done), 16'(rsp_if.table_done));
      end
   endfunction

   // both channels observed at the edge, before this edge's updates land
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready)
            check_record();
         if (req_if.valid && req_if.ready) begin
            if (req_if.start_of_table || phase != PH_IDLE)
               parsed_bytes++;
            parse_byte(req_if.data_byte, req_if.start_of_table);
         end
         if ((rsp_if.valid && rsp_if.ready) || (req_if.valid && req_if.ready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
   end

   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $error("no item moved for %0d cycles", STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic send_byte(input logic [7:0] value, input logic first);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.data_byte      <= value;
      req_if.start_of_table <= first;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
   endtask

   task automatic send_word(input logic [15:0] value);
      send_byte(value[15:8], 1'b0);
      send_byte(value[7:0], 1'b0);
   endtask

   task automatic send_start(input logic [15:0] count);
      send_byte(count[15:8], 1'b1);
      send_byte(count[7:0], 1'b0);
   endtask

   task automatic send_item(output logic bad);
      logic [7:0] tag;
      bad = 1'b0;
      if ($urandom_range(99) < 3) begin
         tag = 8'($urandom_range(TAG_MAX + 1, 255));
         bad = 1'b1;
      end else begin
         tag = 8'($urandom_range(0, TAG_MAX));
      end
      send_byte(tag, 1'b0);
      if (tag == TAG_OBJECT || tag == TAG_UNINIT)
         send_word(16'($urandom));
   endtask

   task automatic send_section(output logic bad);
      int n;
      n   = $urandom_range(0, 3);
      bad = 1'b0;
      send_word(16'(n));
      for (int i = 0; i < n && !bad; i++)
         send_item(bad);
   endtask

   task automatic send_frame(output logic aborted);
      int         pick;
      logic [7:0] ftype;
      pick    = $urandom_range(99);
      aborted = 1'b0;
      if (pick < 14) begin
         send_byte(8'($urandom_range(SAME_MIN, SAME_MAX)), 1'b0);
      end else if (pick < 28) begin
         send_byte(8'($urandom_range(SAME_LOCALS_BASE, SAME_LOCALS_MAX)), 1'b0);
         send_item(aborted);
      end else if (pick < 36) begin
         send_byte(SAME_LOCALS_WIDE, 1'b0);
         send_word(16'($urandom));
         send_item(aborted);
      end else if (pick < 46) begin
         send_byte(8'($urandom_range(SAME_LOCALS_WIDE + 1, CHOP_MAX)), 1'b0);
         send_word(16'($urandom));
      end else if (pick < 54) begin
         send_byte(SAME_WIDE, 1'b0);
         send_word(16'($urandom));
      end else if (pick < 72) begin
         ftype = 8'($urandom_range(SAME_WIDE + 1, APPEND_MAX));
         send_byte(ftype, 1'b0);
         send_word(16'($urandom));
         for (int i = 0; i < ftype - SAME_WIDE && !aborted; i++)
            send_item(aborted);
      end else if (pick < 95) begin
         send_byte(FULL_FRAME, 1'b0);
         send_word(16'($urandom));
         send_section(aborted);
         if (!aborted)
            send_section(aborted);
      end else begin
         send_byte(8'($urandom_range(SAME_LOCALS_MAX + 1, RESERVED_MAX)), 1'b0);
         aborted = 1'b1;
      end
   endtask

   task automatic send_random_table();
      logic [15:0] count;
      int          frames;
      logic        aborted;
      count = 16'($urandom_range(1, 6));
      if ($urandom_range(99) < 5)
         count = '0;
      else if ($urandom_range(99) < 4)
         count = 16'($urandom_range(256, 65535));
      frames = (count > 6) ? $urandom_range(1, 4) : int'(count);
      // cut some tables short so the next start lands mid-table
      if (frames > 0 && $urandom_range(99) < 8)
         frames = $urandom_range(0, frames - 1);
      aborted = 1'b0;
      send_start(count);
      for (int i = 0; i < frames && !aborted; i++)
         send_frame(aborted);
      // trailing junk: dropped after a clean end, parsed as garbage after a cut
      if ($urandom_range(99) < 15)
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
   endtask

   task automatic test_idle_and_empty();
      send_byte(8'hA5, 1'b0);
      send_start(16'h0000);
      send_byte(8'h5A, 1'b0);
   endtask

   task automatic test_frame_kinds();
      send_start(16'd4);
      send_byte(SAME_MAX, 1'b0);
      send_byte(SAME_LOCALS_MAX, 1'b0);
      send_byte(TAG_OBJECT, 1'b0);
      send_word(16'hFFFF);
      send_byte(FULL_FRAME, 1'b0);
      send_word(16'hFFFF);
      send_word(16'd1);
      send_byte(TAG_UNINIT, 1'b0);
      send_word(16'h0000);
      send_word(16'd0);
      send_byte(8'(SAME_WIDE + 8'd1), 1'b0);
      send_word(16'h0000);
      send_byte(TAG_LONG, 1'b0);
   endtask

   task automatic test_errors();
      send_start(16'd2);
      send_byte(8'(SAME_LOCALS_MAX + 8'd1), 1'b0);
      send_start(16'd3);
      send_byte(SAME_MIN, 1'b0);
      // restart in the middle of a table
      send_start(16'd1);
      send_byte(RESERVED_MAX, 1'b0);
      send_byte(8'h11, 1'b0);
      send_start(16'h0100);
      send_byte(SAME_LOCALS_BASE, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_start(16'd1);
      send_byte(SAME_LOCALS_BASE, 1'b0);
      send_byte(TAG_TOP, 1'b0);
   endtask

   task automatic test_random_tables(input int goal);
      int first_count;
      first_count = parsed_bytes;
      while (parsed_bytes - first_count < goal)
         send_random_table();
   endtask

   initial begin
      reset                 = 1'b1;
      req_if.valid          = 1'b0;
      req_if.data_byte      = '0;
      req_if.start_of_table = 1'b0;
      rsp_if.ready          = 1'b0;
      clear_parser();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_idle_and_empty();
      test_frame_kinds();
      test_errors();
      test_random_tables(RANDOM_BYTES);
      send_idle_pct = 66;
      recv_idle_pct = 9;
      test_random_tables(RANDOM_BYTES);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_tables(RANDOM_BYTES);
      req_if.valid <= 1'b0;

      while (expected_records.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("parsed %0d bytes under three stall patterns, %0d records checked",
               parsed_bytes, records_seen);
      $display("headers %0d, items %0d, stack counts %0d, bad types %0d, bad tags %0d",
               kind_seen[REC_FRAME], kind_seen[REC_ITEM], kind_seen[REC_STACK],
               kind_seen[REC_BAD_TYPE], kind_seen[REC_BAD_TAG]);
      if (error_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
